>>> rtl/prc_pkg.sv
`default_nettype none

package prc_pkg;

  localparam int NumDigits = 9;
  localparam int DigitW    = 4;
  localparam int InW       = 30;
  localparam int RankW     = 19;
  localparam int CntW      = 4;

  // Reduce an input of ten decimal digits to its low nine.
  localparam logic [InW-1:0] Billion = 30'd1_000_000_000;

  // Division by ten: q = (v * RecipDiv10) >> RecipShift, exact for any 32-bit v.
  localparam int             RecipW     = 32;
  localparam logic [RecipW-1:0] RecipDiv10 = 32'hCCCC_CCCD;
  localparam int             RecipShift = 35;
  localparam int             ProdW      = InW + RecipW;

  // Weight of a count by the number of positions after it.
  localparam logic [RankW-1:0] Factorial [NumDigits] = '{
    19'd1, 19'd1, 19'd2, 19'd6, 19'd24, 19'd120, 19'd720, 19'd5040, 19'd40320
  };

  // Position 0 is the most significant digit.
  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

>>> rtl/prc_front.sv
`default_nettype none

module prc_front
  import prc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [InW-1:0]   packed_digits_i,
  input  wire q_stat_t          q_stat_i,
  output logic                  push_o,
  output digits_t               push_digits_o
);

  typedef struct packed {
    logic [InW-1:0] rem;
    digits_t        digits;
  } fe_stage_t;

  localparam int Last = NumDigits - 1;

  fe_stage_t              stage_q [NumDigits];
  fe_stage_t              stage_d [NumDigits];
  logic [NumDigits-1:0]   vld_q;
  logic                   fe_en;
  logic [ProdW-1:0]       prod     [NumDigits];
  logic [InW-1:0]         quot     [NumDigits];
  logic [DigitW-1:0]      quot_x10 [NumDigits];

  // Freeze the whole split pipeline only when its last beat cannot enter the queue.
  assign fe_en      = !vld_q[Last] || !q_stat_i.full;
  assign in_stall_o = !fe_en;

  always_comb begin
    stage_d[0].rem    = (packed_digits_i >= Billion) ? (packed_digits_i - Billion)
                                                     : packed_digits_i;
    stage_d[0].digits = '0;
    prod[0]     = '0;
    quot[0]     = '0;
    quot_x10[0] = '0;
    // Peel one decimal digit per stage, least significant first.
    for (int i = 1; i < NumDigits; i++) begin
      prod[i]     = ProdW'(stage_q[i-1].rem) * ProdW'(RecipDiv10);
      quot[i]     = InW'(prod[i] >> RecipShift);
      quot_x10[i] = (quot[i][DigitW-1:0] << 3) + (quot[i][DigitW-1:0] << 1);
      stage_d[i].rem    = quot[i];
      stage_d[i].digits = stage_q[i-1].digits;
      stage_d[i].digits[NumDigits-i] = stage_q[i-1].rem[DigitW-1:0] - quot_x10[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (fe_en) begin
      vld_q <= {vld_q[NumDigits-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe_en) begin
      for (int i = 0; i < NumDigits; i++) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

  // The remainder left after eight divisions is the leading digit.
  always_comb begin
    push_digits_o    = stage_q[Last].digits;
    push_digits_o[0] = stage_q[Last].rem[DigitW-1:0];
  end

  assign push_o = vld_q[Last] && fe_en;

endmodule

`default_nettype wire

>>> rtl/prc_queue.sv
`default_nettype none

module prc_queue
  import prc_pkg::*;
#(
  parameter int Depth = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire digits_t push_digits_i,
  input  wire logic    pop_i,
  output digits_t      pop_digits_o,
  output q_stat_t      q_stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  digits_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign q_stat_o.full  = (count_q == CntW'(Depth));
  assign q_stat_o.empty = (count_q == '0);
  assign do_push        = push_i && !q_stat_o.full;
  assign do_pop         = pop_i && !q_stat_o.empty;
  assign pop_digits_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_digits_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/prc_back.sv
`default_nettype none

module prc_back
  import prc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire q_stat_t          q_stat_i,
  output logic                  pop_o,
  input  wire digits_t          pop_digits_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [RankW-1:0]      rank_o
);

  localparam int Split = 5;

  logic                 be_en;
  logic                 cnt_vld_q;
  logic                 sum_vld_q;
  logic                 out_vld_q;
  logic [CntW-1:0]      cnt_d [NumDigits];
  logic [CntW-1:0]      cnt_q [NumDigits];
  logic [RankW-1:0]     term  [NumDigits];
  logic [RankW-1:0]     sum_lo_d;
  logic [RankW-1:0]     sum_hi_d;
  logic [RankW-1:0]     sum_lo_q;
  logic [RankW-1:0]     sum_hi_q;
  logic [RankW-1:0]     rank_q;

  // Advance all stages together unless the held result is stalled.
  assign be_en = !out_vld_q || !out_stall_i;
  assign pop_o = be_en && !q_stat_i.empty;

  // Count later digits that are smaller than each position.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      cnt_d[i] = '0;
      for (int j = i + 1; j < NumDigits; j++) begin
        cnt_d[i] = cnt_d[i] + CntW'(pop_digits_i[j] < pop_digits_i[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      term[i] = RankW'(cnt_q[i]) * Factorial[NumDigits-1-i];
    end
    sum_lo_d = '0;
    sum_hi_d = '0;
    for (int i = 0; i < Split; i++) begin
      sum_lo_d = sum_lo_d + term[i];
    end
    for (int i = Split; i < NumDigits; i++) begin
      sum_hi_d = sum_hi_d + term[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (be_en) begin
      cnt_vld_q <= !q_stat_i.empty;
      sum_vld_q <= cnt_vld_q;
      out_vld_q <= sum_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be_en) begin
      cnt_q    <= cnt_d;
      sum_lo_q <= sum_lo_d;
      sum_hi_q <= sum_hi_d;
      rank_q   <= sum_lo_q + sum_hi_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign rank_o      = rank_q;

endmodule

`default_nettype wire

>>> rtl/permutation_rank_cantor.sv
// Channel  | Valid        | Stall        | Payload
// input    | in_valid_i   | in_stall_o   | packed_digits_i [29:0]
// output   | out_valid_o  | out_stall_i  | rank_o [18:0]
//
// One beat per cycle unless stalled; an output stall freezes only the rank unit.
// The digit split (a billions reduce, then eight stages of one constant multiply each)
// feeds a small queue.
// The rank unit (count, weight, sum) drains the queue and holds its result register.
// The input stalls when the queue is full and the last split stage holds a beat.
// Reset clears all valid bits and queue pointers; payload registers are not reset.
`default_nettype none

module permutation_rank_cantor
  import prc_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [InW-1:0]   packed_digits_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [RankW-1:0]      rank_o
);

  // Front to queue: one beat of nine split digits per push.
  logic    push;
  digits_t push_digits;
  // Queue to back.
  logic    pop;
  digits_t pop_digits;
  q_stat_t q_stat;

  // Front: drop the billions digit, then split into decimal digits.
  prc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .packed_digits_i (packed_digits_i),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_digits_o   (push_digits)
  );

  // Queue decouples the split from the rank unit so each stalls on its own.
  prc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_digits_i (push_digits),
    .pop_i         (pop),
    .pop_digits_o  (pop_digits),
    .q_stat_o      (q_stat)
  );

  // Back: count smaller later digits, weight by factorials, sum, hold result.
  prc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .pop_digits_i (pop_digits),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rank_o       (rank_o)
  );

endmodule

`default_nettype wire

>>> rtl/prc_checker.sv
`default_nettype none

module prc_checker
  import prc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_o,
  input  wire logic [InW-1:0]   packed_digits_i,
  input  wire logic             out_valid_o,
  input  wire logic             out_stall_i,
  input  wire logic [RankW-1:0] rank_o
);

  localparam logic [RankW-1:0] MaxRank = 19'd362879;

  // Hold a stalled input beat.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(packed_digits_i))
    else $error("stalled input beat changed");

  // Hold a stalled result beat.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_rank_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(rank_o))
    else $error("stalled rank changed");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rank_o <= MaxRank)
    else $error("rank out of range");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result beat during reset");

endmodule

bind permutation_rank_cantor prc_checker u_prc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .packed_digits_i (packed_digits_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .rank_o          (rank_o)
);

`default_nettype wire
